>>> hdl/lsp_pkg.sv
`timescale 1ns / 1ps
package lsp_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned AtanEntries    = 24;
  localparam int unsigned DivBits        = 33;
  localparam int unsigned QueueDepth     = 4;
  localparam int unsigned CordW          = 28;
  localparam int unsigned ZW             = 26;
  localparam logic [23:0] InvGainQ24     = 24'd10188014;

  typedef struct packed {
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic               vertical;
    logic               saturated;
    logic        [17:0] length;
    logic signed [15:0] angle;
  } out_item_t;

  // classified item passed from front to back
  typedef struct packed {
    logic signed [15:0] x1;
    logic signed [15:0] y1;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic               vert;
    logic               zero;
  } work_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    case (idx)
      5'd0:  r = 26'sd2949120;
      5'd1:  r = 26'sd1740967;
      5'd2:  r = 26'sd919879;
      5'd3:  r = 26'sd466945;
      5'd4:  r = 26'sd234379;
      5'd5:  r = 26'sd117304;
      5'd6:  r = 26'sd58666;
      5'd7:  r = 26'sd29335;
      5'd8:  r = 26'sd14668;
      5'd9:  r = 26'sd7334;
      5'd10: r = 26'sd3667;
      5'd11: r = 26'sd1833;
      5'd12: r = 26'sd917;
      5'd13: r = 26'sd458;
      5'd14: r = 26'sd229;
      5'd15: r = 26'sd115;
      5'd16: r = 26'sd57;
      5'd17: r = 26'sd29;
      5'd18: r = 26'sd14;
      5'd19: r = 26'sd7;
      5'd20: r = 26'sd4;
      5'd21: r = 26'sd2;
      5'd22: r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> hdl/line_segment_properties.sv
`timescale 1ns / 1ps
// Takes one segment per cycle while full is low. The front stage registers the
// points and their differences into a four-entry queue; the back end is a fully
// pipelined restoring divider (one quotient bit per stage, 33 stages) running
// beside a vectoring CORDIC of CORDIC_STEPS stages (capped at AtanEntries),
// followed by three finishing stages. A held result stalls the back pipeline;
// the front register and the queue then absorb up to five more segments
// before full.
module line_segment_properties #(
  parameter int unsigned CORDIC_STEPS = lsp_pkg::CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  lsp_pkg::in_item_t  in_i,
  output logic               empty,
  input  logic               pop,
  output lsp_pkg::out_item_t out_o
);

  logic           wr, q_full, q_valid, take, b_valid;
  lsp_pkg::work_t wr_data, rd_data;

  lsp_front u_front (
    .clk_i, .rst_ni, .push_i(push), .in_i, .full_o(full),
    .wr_o(wr), .wr_data_o(wr_data), .q_full_i(q_full)
  );

  lsp_queue u_queue (
    .clk_i, .rst_ni, .wr_i(wr), .wr_data_i(wr_data), .full_o(q_full),
    .valid_o(q_valid), .rd_data_o(rd_data), .rd_i(take)
  );

  lsp_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i, .rst_ni, .valid_i(q_valid), .item_i(rd_data), .take_o(take),
    .valid_o(b_valid), .res_o(out_o), .pop_i(pop)
  );

  assign empty = !b_valid;

  a_vert_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_o.vertical |-> out_o.slope == '0 && out_o.intercept == '0)
    else $error("vertical result with nonzero slope");
  a_angle_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_o.angle <= 16'sd23040 && out_o.angle >= -16'sd23040)
    else $error("angle out of range");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_o))
    else $error("result lost while held");

endmodule

>>> hdl/lsp_front.sv
`timescale 1ns / 1ps
module lsp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lsp_pkg::in_item_t in_i,
  output logic              full_o,
  output logic              wr_o,
  output lsp_pkg::work_t    wr_data_o,
  input  logic              q_full_i
);

  logic           valid_q;
  lsp_pkg::work_t item_q;
  logic           adv;
  logic signed [16:0] dx, dy;

  assign adv    = !valid_q || !q_full_i;
  assign full_o = !adv;
  assign wr_o   = valid_q && !q_full_i;
  assign wr_data_o = item_q;

  assign dx = 17'(in_i.second_x) - 17'(in_i.first_x);
  assign dy = 17'(in_i.second_y) - 17'(in_i.first_y);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && push_i) begin
      item_q.x1   <= in_i.first_x;
      item_q.y1   <= in_i.first_y;
      item_q.dx   <= dx;
      item_q.dy   <= dy;
      item_q.vert <= (dx == '0);
      item_q.zero <= (dx == '0) && (dy == '0);
    end
  end

endmodule

>>> hdl/lsp_queue.sv
`timescale 1ns / 1ps
module lsp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  lsp_pkg::work_t wr_data_i,
  output logic           full_o,
  output logic           valid_o,
  output lsp_pkg::work_t rd_data_o,
  input  logic           rd_i
);

  localparam int unsigned AW = $clog2(lsp_pkg::QueueDepth);

  lsp_pkg::work_t mem_q [lsp_pkg::QueueDepth];
  logic [AW-1:0]  wp_q, rp_q;
  logic [AW:0]    cnt_q;
  logic           do_rd;

  assign valid_o   = cnt_q != '0;
  assign full_o    = cnt_q == (AW+1)'(lsp_pkg::QueueDepth);
  assign rd_data_o = mem_q[rp_q];
  assign do_rd     = rd_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 1'b1;
      if (do_rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr_i) - (AW+1)'(do_rd);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wr_data_i;
  end

endmodule

>>> hdl/lsp_back.sv
`timescale 1ns / 1ps
// pipelined back end: restoring divider, cordic stages, then finishing stages
module lsp_back #(
  parameter int unsigned CORDIC_STEPS = lsp_pkg::CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  lsp_pkg::work_t     item_i,
  output logic               take_o,
  output logic               valid_o,
  output lsp_pkg::out_item_t res_o,
  input  logic               pop_i
);

  localparam int unsigned NS = (CORDIC_STEPS > lsp_pkg::AtanEntries) ?
                               lsp_pkg::AtanEntries : CORDIC_STEPS;
  localparam int unsigned DB = lsp_pkg::DivBits;
  localparam int unsigned CW = lsp_pkg::CordW;
  localparam int unsigned ZW = lsp_pkg::ZW;
  localparam int unsigned NP = (DB > NS ? DB : NS) + 4;

  // pipeline stall when the output holds and the last stage is full
  logic en;
  logic [NP-1:0] v_q;
  assign en     = !(valid_o && !pop_i);
  assign take_o = en;

  // divider lanes: |dy|<<16 / |dx|, one quotient bit per stage
  logic [DB-1:0] num_q [DB+1];
  logic [16:0]   den_q [DB+1];
  logic [17:0]   rem_q [DB+1];
  logic [DB-1:0] quo_q [DB+1];
  logic          neg_q [DB+1];

  // cordic lanes
  logic signed [CW-1:0] cx_q [NS+1];
  logic signed [CW-1:0] cy_q [NS+1];
  logic signed [ZW-1:0] cz_q [NS+1];
  logic signed [8:0]    base_q [NS+1];

  // side data delayed alongside the divider and the finishing stages
  lsp_pkg::work_t w_q [NP];

  logic [16:0] adx, ady;
  assign adx = item_i.dx[16] ? 17'(-item_i.dx) : item_i.dx;
  assign ady = item_i.dy[16] ? 17'(-item_i.dy) : item_i.dy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else if (en) v_q <= {v_q[NP-2:0], valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q[0] <= DB'({ady, 16'd0});
      den_q[0] <= adx;
      rem_q[0] <= '0;
      quo_q[0] <= '0;
      neg_q[0] <= item_i.dx[16] ^ item_i.dy[16];
      w_q[0]   <= item_i;
      cx_q[0]  <= item_i.dx[16] ? -(CW'(item_i.dx) <<< 8) : (CW'(item_i.dx) <<< 8);
      cy_q[0]  <= item_i.dx[16] ? -(CW'(item_i.dy) <<< 8) : (CW'(item_i.dy) <<< 8);
      cz_q[0]  <= '0;
      base_q[0] <= !item_i.dx[16] ? 9'sd0 : (item_i.dy[16] ? -9'sd180 : 9'sd180);
      for (int k = 1; k < NP; k++) w_q[k] <= w_q[k-1];
    end
  end

  for (genvar s = 0; s < DB; s++) begin : g_div
    logic [18:0] tr;
    logic        ge;
    assign tr = {rem_q[s], num_q[s][DB-1-s]};
    assign ge = tr >= 19'(den_q[s]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        num_q[s+1] <= num_q[s];
        den_q[s+1] <= den_q[s];
        neg_q[s+1] <= neg_q[s];
        rem_q[s+1] <= ge ? 18'(tr - 19'(den_q[s])) : tr[17:0];
        quo_q[s+1] <= {quo_q[s][DB-2:0], ge};
      end
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_cord
    logic signed [CW-1:0] xs, ys;
    assign xs = cx_q[s] >>> s;
    assign ys = cy_q[s] >>> s;
    always_ff @(posedge clk_i) begin
      if (en) begin
        base_q[s+1] <= base_q[s];
        if (!cy_q[s][CW-1]) begin
          cx_q[s+1] <= cx_q[s] + ys;
          cy_q[s+1] <= cy_q[s] - xs;
          cz_q[s+1] <= cz_q[s] + lsp_pkg::atan_lut(5'(s));
        end else begin
          cx_q[s+1] <= cx_q[s] - ys;
          cy_q[s+1] <= cy_q[s] + xs;
          cz_q[s+1] <= cz_q[s] - lsp_pkg::atan_lut(5'(s));
        end
      end
    end
  end

  // cordic results wait for the divider
  localparam int unsigned CD = NP - 4 - NS;
  logic signed [CW-1:0] xd_q [CD+1];
  logic signed [ZW-1:0] zd_q [CD+1];
  logic signed [8:0]    bd_q [CD+1];
  always_comb begin
    xd_q[0] = cx_q[NS];
    zd_q[0] = cz_q[NS];
    bd_q[0] = base_q[NS];
  end
  for (genvar s = 0; s < CD; s++) begin : g_cdly
    always_ff @(posedge clk_i) begin
      if (en) begin
        xd_q[s+1] <= xd_q[s];
        zd_q[s+1] <= zd_q[s];
        bd_q[s+1] <= bd_q[s];
      end
    end
  end
  localparam int unsigned DD = NP - 4 - DB;
  logic [DB-1:0] qd_q [DD+1];
  logic          nd_q [DD+1];
  always_comb begin
    qd_q[0] = quo_q[DB];
    nd_q[0] = neg_q[DB];
  end
  for (genvar s = 0; s < DD; s++) begin : g_ddly
    always_ff @(posedge clk_i) begin
      if (en) begin
        qd_q[s+1] <= qd_q[s];
        nd_q[s+1] <= nd_q[s];
      end
    end
  end

  // finishing stage 1: saturate slope, length product, angle
  lsp_pkg::work_t wf;
  assign wf = w_q[NP-3];
  logic signed [34:0] sl_full;
  logic signed [31:0] sl_q;
  logic               ssat_q;
  logic [51:0]        lp_q;
  logic signed [15:0] an_q;
  logic signed [ZW+9:0] asum;
  logic signed [ZW:0]   afl;
  logic [CW-2:0]        xpos;
  assign sl_full = nd_q[DD] ? -$signed({2'b00, qd_q[DD]}) : $signed({2'b00, qd_q[DD]});
  assign asum = (36'(bd_q[CD]) <<< 16) + 36'(zd_q[CD]) + 36'sd256;
  assign afl  = (ZW+1)'(asum >>> 9);
  assign xpos = xd_q[CD][CW-1] ? '0 : xd_q[CD][CW-2:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sl_full > 35'sd2147483647) begin
        sl_q <= 32'sh7fffffff; ssat_q <= 1'b1;
      end else if (sl_full < -35'sd2147483648) begin
        sl_q <= 32'sh80000000; ssat_q <= 1'b1;
      end else begin
        sl_q <= 32'(sl_full); ssat_q <= 1'b0;
      end
      lp_q <= 52'(xpos) * 52'(lsp_pkg::InvGainQ24);
      if (afl > 27'sd23040) an_q <= 16'sd23040;
      else if (afl < -27'sd23040) an_q <= -16'sd23040;
      else an_q <= 16'(afl);
    end
  end

  // finishing stage 2: x1 * slope, rounded and saturated length
  logic signed [47:0] pr_q;
  logic signed [31:0] sl2_q;
  logic               ssat2_q;
  logic [17:0]        ln_q;
  logic signed [15:0] an2_q;
  logic [52:0]        lr;
  assign lr = 53'(lp_q) + 53'(64'h80000000);
  always_ff @(posedge clk_i) begin
    if (en) begin
      pr_q    <= 48'(wf.x1) * 48'(sl_q);
      sl2_q   <= sl_q;
      ssat2_q <= ssat_q;
      ln_q    <= (lr[52:32] > 21'd262143) ? 18'h3ffff : lr[49:32];
      an2_q   <= an_q;
    end
  end

  // finishing stage 3: intercept, with vertical and zero-length handling into the result
  lsp_pkg::work_t wg;
  assign wg = w_q[NP-2];
  logic signed [48:0] ic;
  assign ic = (49'(wg.y1) <<< 8) - 49'(pr_q >>> 8);
  always_ff @(posedge clk_i) begin
    if (en) begin
      res_o.vertical <= wg.vert;
      res_o.length   <= wg.zero ? '0 : ln_q;
      res_o.angle    <= wg.zero ? '0 : an2_q;
      if (wg.vert) begin
        res_o.slope <= '0; res_o.intercept <= '0; res_o.saturated <= 1'b0;
      end else begin
        res_o.slope <= sl2_q;
        if (ic > 49'sd2147483647) begin
          res_o.intercept <= 32'sh7fffffff; res_o.saturated <= 1'b1;
        end else if (ic < -49'sd2147483648) begin
          res_o.intercept <= 32'sh80000000; res_o.saturated <= 1'b1;
        end else begin
          res_o.intercept <= 32'(ic); res_o.saturated <= ssat2_q;
        end
      end
    end
  end

  assign valid_o = v_q[NP-1];

endmodule

>>> tb/tb_line_segment_properties.sv
`timescale 1ns / 1ps
module tb_line_segment_properties;

  localparam int unsigned Steps = lsp_pkg::CordicStepsDef;
  localparam int unsigned NumRandom = 1800;
  localparam int unsigned StallLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  lsp_pkg::in_item_t in_i = '0;
  lsp_pkg::out_item_t out_o;

  lsp_pkg::in_item_t  seg_q[$];
  lsp_pkg::out_item_t props_q[$];
  int unsigned err_cnt = 0;
  bit stim_done = 1'b0;
  int unsigned push_wait = 0, pop_wait = 0, idle_cycles = 0;

  line_segment_properties #(.CORDIC_STEPS(Steps)) i_dut (
    .clk_i, .rst_ni, .push, .full, .in_i, .empty, .pop, .out_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint unsigned atan_deg(input int i);
    longint unsigned t[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
      29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
    return t[i];
  endfunction

  function automatic longint fl_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(input longint v, inout bit clip);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic lsp_pkg::out_item_t segment_props(input lsp_pkg::in_item_t s);
    lsp_pkg::out_item_t r;
    longint x1, y1, dx, dy, slp, icp, cx, cy, z, base, xs, ys, len, ang;
    longint unsigned produ;
    bit clip;
    int n;
    x1 = s.first_x;
    y1 = s.first_y;
    dx = longint'(s.second_x) - x1;
    dy = longint'(s.second_y) - y1;
    clip = 1'b0;
    slp = 0;
    icp = 0;
    len = 0;
    ang = 0;
    if (dx != 0) begin
      slp = clamp32((dy * 65536) / dx, clip);
      icp = clamp32(y1 * 256 - fl_shr(x1 * slp, 8), clip);
    end
    if (dx != 0 || dy != 0) begin
      cx = dx * 256;
      cy = dy * 256;
      z = 0;
      base = 0;
      n = (Steps > 24) ? 24 : Steps;
      if (dx < 0) begin
        cx = -cx;
        cy = -cy;
        base = (dy >= 0) ? 180 : -180;
      end
      for (int i = 0; i < n; i++) begin
        xs = fl_shr(cx, i);
        ys = fl_shr(cy, i);
        if (cy >= 0) begin
          cx += ys;
          cy -= xs;
          z += longint'(atan_deg(i));
        end else begin
          cx -= ys;
          cy += xs;
          z -= longint'(atan_deg(i));
        end
      end
      if (cx < 0) cx = 0;
      produ = longint'(cx) * 64'd10188014 + 64'h8000_0000;
      len = longint'(produ >> 32);
      if (len > 262143) len = 262143;
      ang = fl_shr(base * 65536 + z + 256, 9);
      if (ang > 23040) ang = 23040;
      if (ang < -23040) ang = -23040;
    end
    r.slope = slp[31:0];
    r.intercept = icp[31:0];
    r.vertical = (dx == 0);
    r.saturated = clip;
    r.length = len[17:0];
    r.angle = ang[15:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    err_cnt++;
  endtask

  function automatic lsp_pkg::in_item_t mk_seg(input int a, input int b, input int c,
                                               input int d);
    lsp_pkg::in_item_t s;
    s.first_x = a[15:0];
    s.first_y = b[15:0];
    s.second_x = c[15:0];
    s.second_y = d[15:0];
    return s;
  endfunction

  function automatic logic [15:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 64) - 32);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        props_q.push_back(segment_props(in_i));
        void'(seg_q.pop_front());
        push_wait <= $urandom_range(0, 3) == 0 ? $urandom_range(0, 18) : 0;
        if (seg_q.size() != 0 && !($urandom_range(0, 3) == 0)) begin
          in_i <= seg_q[0];
        end else begin
          push <= 1'b0;
        end
      end else if (!push) begin
        if (push_wait != 0) begin
          push_wait <= push_wait - 1;
        end else if (seg_q.size() != 0) begin
          in_i <= seg_q[0];
          push <= 1'b1;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    lsp_pkg::out_item_t w;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (props_q.size() == 0) begin
          report_mismatch("unexpected beat", 0, 0);
        end else begin
          w = props_q.pop_front();
          if (out_o.slope !== w.slope) report_mismatch("slope", out_o.slope, w.slope);
          if (out_o.intercept !== w.intercept)
            report_mismatch("intercept", out_o.intercept, w.intercept);
          if (out_o.vertical !== w.vertical)
            report_mismatch("vertical", out_o.vertical, w.vertical);
          if (out_o.saturated !== w.saturated)
            report_mismatch("saturated", out_o.saturated, w.saturated);
          if (out_o.length !== w.length) report_mismatch("length", out_o.length, w.length);
          if (out_o.angle !== w.angle) report_mismatch("angle", out_o.angle, w.angle);
        end
        pop_wait = $urandom_range(0, 2) == 0 ? $urandom_range(0, 18) : 0;
        pop <= (pop_wait == 0);
      end else if (pop_wait != 0) begin
        pop_wait--;
        pop <= (pop_wait == 0);
      end else begin
        pop <= 1'b1;
      end
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int tail;
    // directed: extremes, verticals, equal points, saturation, each quadrant
    seg_q.push_back(mk_seg(0, 0, 0, 0));
    seg_q.push_back(mk_seg(-32768, -32768, -32768, -32768));
    seg_q.push_back(mk_seg(5, 7, 5, 300));
    seg_q.push_back(mk_seg(5, 300, 5, 7));
    seg_q.push_back(mk_seg(-32768, -32768, 32767, 32767));
    seg_q.push_back(mk_seg(32767, 32767, -32768, -32768));
    seg_q.push_back(mk_seg(-32768, 32767, 32767, -32768));
    seg_q.push_back(mk_seg(0, -32768, 1, 32767));
    seg_q.push_back(mk_seg(0, 32767, 1, -32768));
    seg_q.push_back(mk_seg(32767, 32767, 32766, -32768));
    seg_q.push_back(mk_seg(-32768, 0, -32767, 0));
    seg_q.push_back(mk_seg(256, 256, 0, 256));
    seg_q.push_back(mk_seg(0, 0, -256, 256));
    seg_q.push_back(mk_seg(0, 0, -256, -256));
    seg_q.push_back(mk_seg(0, 0, 256, -256));
    seg_q.push_back(mk_seg(0, 0, -256, 0));
    seg_q.push_back(mk_seg(0, 0, -256, -1));
    seg_q.push_back(mk_seg(32767, -32768, -32768, -32767));
    seg_q.push_back(mk_seg(-32768, 100, 32767, 100));
    seg_q.push_back(mk_seg(1, 1, 2, 2));
    for (int i = 0; i < NumRandom; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        lsp_pkg::in_item_t s;
        s = {rnd_coord(), rnd_coord(), 16'h0, rnd_coord()};
        s.second_x = s.first_x;
        if ($urandom_range(0, 1)) s.second_y = s.first_y;
        seg_q.push_back(s);
      end else begin
        seg_q.push_back({rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord()});
      end
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (seg_q.size() != 0 || props_q.size() != 0) begin
      @(posedge clk_i);
      if (idle_cycles >= StallLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
    tail = 0;
    while (tail < 100) begin
      @(posedge clk_i);
      tail++;
    end
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
